>>> sv/lr_pkg.sv
package lr_pkg;

   localparam int COORD_BITS_DEFAULT = 6;
   localparam int COLOR_BITS = 4;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      logic neg;
      logic zero;
   } alu_flags_type;

endpackage

>>> sv/lr_alu.sv
module lr_alu #(
   parameter int WIDTH = lr_pkg::COORD_BITS_DEFAULT + 3
) (
   input  logic [WIDTH-1:0]    op_a,
   input  logic [WIDTH-1:0]    op_b,
   input  lr_pkg::alu_op_type  op,
   output logic [WIDTH-1:0]    result,
   output lr_pkg::alu_flags_type flags
);
   import lr_pkg::*;

   logic [WIDTH-1:0] b_eff;
   logic             carry_in;

   // Subtraction is the two's complement add of the inverted operand.
   assign b_eff    = (op == ALU_SUB) ? ~op_b : op_b;
   assign carry_in = (op == ALU_SUB);
   assign result   = op_a + b_eff + WIDTH'(carry_in);

   assign flags.neg  = result[WIDTH-1];
   assign flags.zero = (result == '0);

endmodule

>>> sv/line_rasterizer.sv
// Bresenham line rasterizer. A command (start point, end point, color) is
// taken when req_ready is high, and the pixels of the line are then sent
// on the rsp_ channel from the start point through the end point, the end
// point flagged by rsp_last_pixel. All arithmetic runs through one shared
// add/subtract unit under a small sequencer, so the block accepts no new
// command until the last pixel of the current one has been transferred.
// Setup steps through capture, two deltas with their magnitudes, the
// steepness compare and the axis load. Each pixel then passes through
// one output state plus major step, error add, error test and, if taken,
// error subtract and minor step, the output state holding for as long as
// the consumer keeps rsp_ready low.
module line_rasterizer #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [COORD_BITS-1:0]         req_start_x,
   input  logic [COORD_BITS-1:0]         req_start_y,
   input  logic [COORD_BITS-1:0]         req_end_x,
   input  logic [COORD_BITS-1:0]         req_end_y,
   input  logic [lr_pkg::COLOR_BITS-1:0] req_color,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [COORD_BITS-1:0]         rsp_pixel_x,
   output logic [COORD_BITS-1:0]         rsp_pixel_y,
   output logic [lr_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   output logic                          rsp_last_pixel
);
   import lr_pkg::*;

   // Room for twice the error term, which reaches about three times the
   // major delta, plus a sign bit.
   localparam int EW = COORD_BITS + 3;
   localparam logic [EW-1:0] ONE = EW'(1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DX,
      ST_ABSX,
      ST_DY,
      ST_ABSY,
      ST_CMP,
      ST_LOAD,
      ST_EMIT,
      ST_MSTEP,
      ST_EADD,
      ST_ETEST,
      ST_ESUB,
      ST_NSTEP
   } state_type;

   state_type state_ff;

   logic [COORD_BITS-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic [COLOR_BITS-1:0] color_ff;
   logic [EW-1:0]         dx_ff, dy_ff, dmaj_ff, dmin_ff, err_ff;
   logic                  xneg_ff, yneg_ff, steep_ff, mdec_ff, ndec_ff;
   logic [COORD_BITS-1:0] m_ff, n_ff, m1_ff;

   logic [EW-1:0]  alu_a, alu_b, alu_result;
   alu_op_type     alu_op;
   alu_flags_type  alu_flags;
   logic           last;

   lr_alu #(
      .WIDTH(EW)
   ) u_alu (
      .op_a  (alu_a),
      .op_b  (alu_b),
      .op    (alu_op),
      .result(alu_result),
      .flags (alu_flags)
   );

   always_comb begin
      alu_a  = '0;
      alu_b  = '0;
      alu_op = ALU_ADD;
      case (state_ff)
         ST_DX: begin
            alu_a  = EW'(ex_ff);
            alu_b  = EW'(sx_ff);
            alu_op = ALU_SUB;
         end
         ST_ABSX: begin
            alu_b  = dx_ff;
            alu_op = ALU_SUB;
         end
         ST_DY: begin
            alu_a  = EW'(ey_ff);
            alu_b  = EW'(sy_ff);
            alu_op = ALU_SUB;
         end
         ST_ABSY: begin
            alu_b  = dy_ff;
            alu_op = ALU_SUB;
         end
         ST_CMP: begin
            alu_a  = dx_ff;
            alu_b  = dy_ff;
            alu_op = ALU_SUB;
         end
         ST_MSTEP: begin
            alu_a  = EW'(m_ff);
            alu_b  = ONE;
            alu_op = mdec_ff ? ALU_SUB : ALU_ADD;
         end
         ST_EADD: begin
            alu_a  = err_ff;
            alu_b  = dmin_ff;
         end
         ST_ETEST: begin
            alu_a  = {err_ff[EW-2:0], 1'b0};
            alu_b  = dmaj_ff;
            alu_op = ALU_SUB;
         end
         ST_ESUB: begin
            alu_a  = err_ff;
            alu_b  = dmaj_ff;
            alu_op = ALU_SUB;
         end
         ST_NSTEP: begin
            alu_a  = EW'(n_ff);
            alu_b  = ONE;
            alu_op = ndec_ff ? ALU_SUB : ALU_ADD;
         end
         default: begin
            alu_a  = '0;
            alu_b  = '0;
            alu_op = ALU_ADD;
         end
      endcase
   end

   assign last = (m_ff == m1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  sx_ff    <= req_start_x;
                  sy_ff    <= req_start_y;
                  ex_ff    <= req_end_x;
                  ey_ff    <= req_end_y;
                  color_ff <= req_color;
                  state_ff <= ST_DX;
               end
            end
            ST_DX: begin
               dx_ff    <= alu_result;
               xneg_ff  <= alu_flags.neg;
               state_ff <= ST_ABSX;
            end
            ST_ABSX: begin
               if (xneg_ff) begin
                  dx_ff <= alu_result;
               end
               state_ff <= ST_DY;
            end
            ST_DY: begin
               dy_ff    <= alu_result;
               yneg_ff  <= alu_flags.neg;
               state_ff <= ST_ABSY;
            end
            ST_ABSY: begin
               if (yneg_ff) begin
                  dy_ff <= alu_result;
               end
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               // A negative column-minus-row extent means rows are major.
               steep_ff <= alu_flags.neg;
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               m_ff     <= steep_ff ? sy_ff : sx_ff;
               n_ff     <= steep_ff ? sx_ff : sy_ff;
               m1_ff    <= steep_ff ? ey_ff : ex_ff;
               dmaj_ff  <= steep_ff ? dy_ff : dx_ff;
               dmin_ff  <= steep_ff ? dx_ff : dy_ff;
               mdec_ff  <= steep_ff ? yneg_ff : xneg_ff;
               ndec_ff  <= steep_ff ? xneg_ff : yneg_ff;
               err_ff   <= '0;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (rsp_ready) begin
                  state_ff <= last ? ST_IDLE : ST_MSTEP;
               end
            end
            ST_MSTEP: begin
               m_ff     <= alu_result[COORD_BITS-1:0];
               state_ff <= ST_EADD;
            end
            ST_EADD: begin
               err_ff   <= alu_result;
               state_ff <= ST_ETEST;
            end
            ST_ETEST: begin
               // The minor axis steps only when twice the error strictly
               // exceeds the major delta.
               if (!alu_flags.neg && !alu_flags.zero) begin
                  state_ff <= ST_ESUB;
               end else begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_ESUB: begin
               err_ff   <= alu_result;
               state_ff <= ST_NSTEP;
            end
            ST_NSTEP: begin
               n_ff     <= alu_result[COORD_BITS-1:0];
               state_ff <= ST_EMIT;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_pixel_x     = steep_ff ? n_ff : m_ff;
   assign rsp_pixel_y     = steep_ff ? m_ff : n_ff;
   assign rsp_pixel_color = color_ff;
   assign rsp_last_pixel  = last;

endmodule
